FILE: hdl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// shared types and constants of the set-associative lru cache tag model
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam logic [1:0] CMD_IGNORE = 2'd0;
   localparam logic [1:0] CMD_LOAD   = 2'd1;
   localparam logic [1:0] CMD_STORE  = 2'd2;
   localparam logic [1:0] CMD_MODIFY = 2'd3;

   localparam logic [1:0] OUT_NONE  = 2'd0;
   localparam logic [1:0] OUT_HIT   = 2'd1;
   localparam logic [1:0] OUT_MISS  = 2'd2;
   localparam logic [1:0] OUT_EVICT = 2'd3;

   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_WAYS       = 2'd1;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;    // capture request
      logic read_set;    // read the set rows
      logic update;      // compare and write back, one access
      logic second;      // update belongs to second access
      logic load_out;    // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic modify;      // captured command is modify
      logic ignore;      // captured command is ignore
   } status_type;

endpackage

FILE: hdl/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl
// sequencer: read set, update, repeat for modify (ignore skips both), then hand out result
// ----------------------------------------------------------------------------
module salc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  salc_pkg::status_type  status,
   output salc_pkg::cmd_type     cmd
);

   salc_pkg::state_type state_ff, state_in;
   logic second_ff, second_in;
   logic valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= salc_pkg::ST_IDLE;
         second_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in   = state_ff;
      second_in  = second_ff;
      valid_in   = valid_ff;
      cmd        = '0;
      req_tready = 1'b0;
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      unique case (state_ff)
         salc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               second_in    = 1'b0;
               state_in     = salc_pkg::ST_READ;
            end
         end
         salc_pkg::ST_READ: begin
            if (status.ignore) begin
               state_in = salc_pkg::ST_RESULT;
            end else begin
               cmd.read_set = 1'b1;
               state_in     = salc_pkg::ST_UPDATE;
            end
         end
         salc_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            cmd.second = second_ff;
            if (status.modify && !second_ff) begin
               second_in = 1'b1;
               state_in  = salc_pkg::ST_READ;
            end else begin
               state_in = salc_pkg::ST_RESULT;
            end
         end
         salc_pkg::ST_RESULT: begin
            // result register free (or freeing) before it is loaded
            if (!valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = salc_pkg::ST_IDLE;
            end
         end
         default: state_in = salc_pkg::ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/salc_datapath.sv
// ----------------------------------------------------------------------------
// salc_datapath
// tag, rank and valid storage, lookup, lru update and totals
// ----------------------------------------------------------------------------
module salc_datapath #(
   parameter int MAX_SET_BITS  = 6,
   parameter int MAX_WAYS      = 8,
   parameter int ADDRESS_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  salc_pkg::cmd_type         cmd,
   output salc_pkg::status_type      status,
   input  logic [1:0]                req_command,
   input  logic [ADDRESS_WIDTH-1:0]  req_address,
   input  logic [2:0]                cfg_set_bits,
   input  logic [3:0]                cfg_ways,
   input  logic [4:0]                cfg_block_bits,
   output logic [1:0]                first_outcome,
   output logic [1:0]                second_outcome,
   output logic [31:0]               hit_total,
   output logic [31:0]               miss_total,
   output logic [31:0]               eviction_total
);

   localparam int SETS    = 1 << MAX_SET_BITS;
   localparam int SETW    = MAX_SET_BITS;
   localparam int RANKW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAYW    = $clog2(MAX_WAYS + 1);
   localparam int TAGW    = ADDRESS_WIDTH;
   localparam int SBW     = $clog2(MAX_SET_BITS + 1);
   localparam logic [RANKW-1:0] RANK_TOP = RANKW'(MAX_WAYS - 1);

   // one row per set, all ways side by side
   logic [MAX_WAYS-1:0][TAGW-1:0]  tag_mem  [SETS];
   logic [MAX_WAYS-1:0][RANKW-1:0] rank_mem [SETS];
   logic [MAX_WAYS-1:0]            vld_mem  [SETS];
   // set written since reset; an unwritten set reads as all lines invalid
   logic [SETS-1:0]                seen_ff;

   logic [1:0]               command_ff;
   logic [ADDRESS_WIDTH-1:0] address_ff;
   logic [MAX_WAYS-1:0][TAGW-1:0]  tag_rd_ff;
   logic [MAX_WAYS-1:0][RANKW-1:0] rank_rd_ff;
   logic [MAX_WAYS-1:0]            vld_rd_ff;
   logic                           seen_rd_ff;
   logic [MAX_WAYS-1:0]            vld_row;
   logic [1:0]  first_ff, second_ff, out1_ff, out2_ff;
   logic [31:0] hits_ff, misses_ff, evicts_ff, hit_o_ff, miss_o_ff, evict_o_ff;

   logic [SBW-1:0]  s_eff;
   logic [WAYW-1:0] e_eff;
   logic [4:0]      b_eff;
   logic [SETW-1:0] set_idx;
   logic [TAGW-1:0] tag;
   logic [6:0]      sh;

   always_comb begin
      s_eff = (cfg_set_bits == 3'd0) ? SBW'(1) : SBW'(cfg_set_bits);
      if (32'(cfg_set_bits) > 32'(MAX_SET_BITS)) s_eff = SBW'(MAX_SET_BITS);
      e_eff = (cfg_ways == 4'd0) ? WAYW'(1) : WAYW'(cfg_ways);
      if (32'(cfg_ways) > 32'(MAX_WAYS)) e_eff = WAYW'(MAX_WAYS);
      b_eff = (cfg_block_bits == 5'd0) ? 5'd1 : cfg_block_bits;
      set_idx = SETW'((address_ff >> b_eff) & ((ADDRESS_WIDTH)'(1) << s_eff) - 1'b1);
      sh  = 7'(b_eff) + 7'(s_eff);
      tag = (32'(sh) >= 32'(ADDRESS_WIDTH)) ? '0 : TAGW'(address_ff >> sh);
   end

   assign status.modify = (command_ff == salc_pkg::CMD_MODIFY);
   assign status.ignore = (command_ff == salc_pkg::CMD_IGNORE);

   assign vld_row = seen_rd_ff ? vld_rd_ff : '0;

   // lookup on the registered row
   logic                      hit;
   logic [RANKW-1:0]          hit_rank;
   logic [WAYW-1:0]           hit_way, free_way, victim;
   logic                      has_free;
   logic [RANKW-1:0]          best;
   logic [WAYW-1:0]           sel;
   logic [RANKW:0]            old_rank;
   logic [1:0]                outcome;
   logic [MAX_WAYS-1:0][RANKW-1:0] rank_new;
   logic [MAX_WAYS-1:0][TAGW-1:0]  tag_new;
   logic [MAX_WAYS-1:0]            vld_new;

   always_comb begin
      hit = 1'b0; hit_way = '0; hit_rank = '0;
      has_free = 1'b0; free_way = '0;
      victim = '0; best = rank_rd_ff[0];
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAYW'(i) < e_eff) begin
            if (!hit && vld_row[i] && tag_rd_ff[i] == tag) begin
               hit = 1'b1; hit_way = WAYW'(i); hit_rank = rank_rd_ff[i];
            end
            if (!has_free && !vld_row[i]) begin
               has_free = 1'b1; free_way = WAYW'(i);
            end
            if (i > 0 && rank_rd_ff[i] > best) begin
               best = rank_rd_ff[i]; victim = WAYW'(i);
            end
         end
      end
      if (hit) begin
         sel = hit_way; old_rank = {1'b0, hit_rank}; outcome = salc_pkg::OUT_HIT;
      end else if (has_free) begin
         sel = free_way; old_rank = (RANKW+1)'(MAX_WAYS); outcome = salc_pkg::OUT_MISS;
      end else begin
         sel = victim; old_rank = (RANKW+1)'(MAX_WAYS); outcome = salc_pkg::OUT_EVICT;
      end
      rank_new = rank_rd_ff;
      tag_new  = tag_rd_ff;
      vld_new  = vld_row;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAYW'(i) < e_eff && WAYW'(i) != sel && vld_row[i]
             && {1'b0, rank_rd_ff[i]} < old_rank && rank_rd_ff[i] < RANK_TOP)
            rank_new[i] = rank_rd_ff[i] + 1'b1;
         if (WAYW'(i) == sel) begin
            rank_new[i] = '0;
            tag_new[i]  = tag;
            vld_new[i]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         command_ff <= req_command;
         address_ff <= req_address;
      end
      if (cmd.read_set) begin
         tag_rd_ff  <= tag_mem[set_idx];
         rank_rd_ff <= rank_mem[set_idx];
         vld_rd_ff  <= vld_mem[set_idx];
      end
      if (cmd.update) begin
         tag_mem[set_idx]  <= tag_new;
         rank_mem[set_idx] <= rank_new;
         vld_mem[set_idx]  <= vld_new;
      end
      if (cmd.load_out) begin
         out1_ff    <= first_ff;
         out2_ff    <= second_ff;
         hit_o_ff   <= hits_ff;
         miss_o_ff  <= misses_ff;
         evict_o_ff <= evicts_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         seen_rd_ff <= 1'b0;
         hits_ff    <= '0;
         misses_ff  <= '0;
         evicts_ff  <= '0;
         first_ff   <= salc_pkg::OUT_NONE;
         second_ff  <= salc_pkg::OUT_NONE;
      end else begin
         if (cmd.load_req) begin
            first_ff  <= salc_pkg::OUT_NONE;
            second_ff <= salc_pkg::OUT_NONE;
         end
         if (cmd.read_set) seen_rd_ff <= seen_ff[set_idx];
         if (cmd.update) begin
            seen_ff[set_idx] <= 1'b1;
            if (cmd.second) second_ff <= outcome;
            else            first_ff  <= outcome;
            if (outcome == salc_pkg::OUT_HIT) begin
               if (hits_ff != '1) hits_ff <= hits_ff + 1'b1;
            end else begin
               if (misses_ff != '1) misses_ff <= misses_ff + 1'b1;
               if (outcome == salc_pkg::OUT_EVICT && evicts_ff != '1)
                  evicts_ff <= evicts_ff + 1'b1;
            end
         end
      end
   end

   assign first_outcome  = out1_ff;
   assign second_outcome = out2_ff;
   assign hit_total      = hit_o_ff;
   assign miss_total     = miss_o_ff;
   assign eviction_total = evict_o_ff;

endmodule

FILE: hdl/set_assoc_lru_cache_tag_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tag_model
// tag model of a set-associative cache with lru replacement and totals
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata: command, address
// rsp_      out  rsp_tvalid/rsp_tready  tdata: outcomes and three totals
// csr_      in   csr_wen                csr_index, csr_wdata
//
// transfer to transfer: idle, then one set row read and one write back per
// access (one for load/store, two for modify, none for ignore), then result
// reset clears per-set fill marks, totals and control registers, no clearing pass
// a held result does not block the next request; the block waits only when
// a new result is ready while the old one is still not taken
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tag_model #(
   parameter int MAX_SET_BITS  = 6,
   parameter int MAX_WAYS      = 8,
   parameter int ADDRESS_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // command [1:0], address [ADDRESS_WIDTH+1:2], zero fill
   input  logic [((ADDRESS_WIDTH+2+7)/8)*8-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // first_outcome [1:0], second_outcome [3:2], hit_total [35:4],
   // miss_total [67:36], eviction_total [99:68], zero fill
   output logic [103:0]                    rsp_tdata,
   input  logic                            csr_wen,
   input  logic [1:0]                      csr_index,
   input  logic [4:0]                      csr_wdata
);

   localparam int REQW = ((ADDRESS_WIDTH + 2 + 7) / 8) * 8;

   // configuration registers
   logic [2:0] set_bits_ff;
   logic [3:0] ways_ff;
   logic [4:0] block_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 3'd4;
         ways_ff       <= 4'd1;
         block_bits_ff <= 5'd4;
      end else if (csr_wen) begin
         case (csr_index)
            salc_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
            salc_pkg::CSR_WAYS:       ways_ff       <= csr_wdata[3:0];
            salc_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   salc_pkg::cmd_type    cmd;
   salc_pkg::status_type status;
   logic rsp_valid_q;
   logic [1:0]  first_outcome, second_outcome;
   logic [31:0] hit_total, miss_total, eviction_total;
   logic [REQW-1:0] req_unused;

   assign req_unused = req_tdata;

   salc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_valid_q),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // result register loads on the edge where the controller raises valid
   salc_datapath #(
      .MAX_SET_BITS  (MAX_SET_BITS),
      .MAX_WAYS      (MAX_WAYS),
      .ADDRESS_WIDTH (ADDRESS_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req_unused[1:0]),
      .req_address    (req_unused[ADDRESS_WIDTH+1:2]),
      .cfg_set_bits   (set_bits_ff),
      .cfg_ways       (ways_ff),
      .cfg_block_bits (block_bits_ff),
      .first_outcome  (first_outcome),
      .second_outcome (second_outcome),
      .hit_total      (hit_total),
      .miss_total     (miss_total),
      .eviction_total (eviction_total)
   );

   assign rsp_tvalid = rsp_valid_q;
   assign rsp_tdata  = {4'd0, eviction_total, miss_total, hit_total,
                        second_outcome, first_outcome};

endmodule
